@@ design/envelope_breakpoint_interpolator_top_assert.svh @@
// ----------------------------------------------------------------------------
// Envelope breakpoint interpolator assertion macros
// Concurrent assertion wrappers that fall away in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ENVELOPE_BREAKPOINT_INTERPOLATOR_TOP_ASSERT_SVH
`define ENVELOPE_BREAKPOINT_INTERPOLATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS
`define EBI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
`define EBI_ASSERT_NEVER(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(prop)) else $error(msg);
`else
`define EBI_ASSERT(lbl, clk, rstn, prop, msg)
`define EBI_ASSERT_NEVER(lbl, clk, rstn, prop, msg)
`endif

`endif

@@ design/ebi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Envelope breakpoint interpolator package
// Shared widths, codes and the control/status bundles of the block.
// ----------------------------------------------------------------------------
package ebi_pkg;

  localparam int MAX_POINTS_DEF = 16;

  localparam int POS_W      = 16;
  localparam int SLOPE_W    = 16;
  localparam int VAL_W      = 8;
  localparam int EIDX_W     = 4;
  localparam int COUNT_W    = 5;
  localparam int PTR_W      = 8;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  localparam logic [PTR_W-1:0]   NONE_INDEX  = 8'hFF;
  localparam logic [COUNT_W-1:0] COUNT_RESET = 5'd1;

  typedef enum logic {
    KIND_TICK = 1'b0,
    KIND_LOAD = 1'b1
  } kind_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POINT_COUNT = 2'd0,
    CFG_SUSTAIN     = 2'd1,
    CFG_LOOP_START  = 2'd2,
    CFG_LOOP_END    = 2'd3
  } cfg_reg_e;

  // Which table entry the read port looks at.
  typedef enum logic [2:0] {
    RD_LAST   = 3'd0,
    RD_SUS    = 3'd1,
    RD_LEND   = 3'd2,
    RD_LSTART = 3'd3,
    RD_ZERO   = 3'd4,
    RD_SCAN   = 3'd5
  } rdsel_e;

  typedef struct packed {
    logic [POS_W-1:0]   position;
    logic [SLOPE_W-1:0] slope;
    logic [VAL_W-1:0]   value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  typedef struct packed {
    logic   tick_cap;
    logic   entry_wr;
    rdsel_e rd_sel;
    logic   cap_last;
    logic   cap_sus;
    logic   cap_lend;
    logic   cap_lstart;
    logic   scan_clr;
    logic   scan_inc;
    logic   cap_prev;
    logic   cap_seg;
    logic   mul;
    logic   lvl_exact;
    logic   lvl_end;
    logic   lvl_interp;
    logic   out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_ge;
    logic scan_eq;
    logic scan_end;
    logic idx_zero;
    logic out_free;
  } status_t;

endpackage

@@ design/ebi_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Envelope input channel
// Valid/ready channel carrying tick and table load words.
// ----------------------------------------------------------------------------
interface ebi_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic [ebi_pkg::POS_W-1:0]           position;
  logic                                released;
  logic [ebi_pkg::EIDX_W-1:0]          entry_index;
  logic [ebi_pkg::POS_W-1:0]           entry_position;
  logic signed [ebi_pkg::SLOPE_W-1:0]  entry_slope;
  logic [ebi_pkg::VAL_W-1:0]           entry_value;

  modport source (
    output valid, kind, position, released, entry_index, entry_position,
    entry_slope, entry_value,
    input  ready
  );
  modport sink (
    input  valid, kind, position, released, entry_index, entry_position,
    entry_slope, entry_value,
    output ready
  );
endinterface

@@ design/ebi_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Envelope output channel
// Valid/ready channel carrying one result word per tick.
// ----------------------------------------------------------------------------
interface ebi_out_if;
  logic                      valid;
  logic                      ready;
  logic [ebi_pkg::VAL_W-1:0] level;
  logic [ebi_pkg::POS_W-1:0] next_position;
  logic                      note_off_arm;

  modport source (
    output valid, level, next_position, note_off_arm,
    input  ready
  );
  modport sink (
    input  valid, level, next_position, note_off_arm,
    output ready
  );
endinterface

@@ design/ebi_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Envelope table RAM
// Generic single write, single read memory with registered read data.
// ----------------------------------------------------------------------------
module ebi_ram #(
  parameter int WIDTH = ebi_pkg::ENTRY_W,
  parameter int DEPTH = ebi_pkg::MAX_POINTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/ebi_ctrl.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Envelope sequencer
// State machine that steps the datapath through one tick.
// ----------------------------------------------------------------------------
`include "envelope_breakpoint_interpolator_top_assert.svh"

module ebi_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  ebi_in_if.sink           in_i,
  input  ebi_pkg::status_t st_i,
  output ebi_pkg::cmd_t    cmd_o
);

  typedef enum logic [9:0] {
    ST_IDLE   = 10'b00_0000_0001,
    ST_LAST   = 10'b00_0000_0010,
    ST_SUS    = 10'b00_0000_0100,
    ST_LEND   = 10'b00_0000_1000,
    ST_LSTART = 10'b00_0001_0000,
    ST_SCAN0  = 10'b00_0010_0000,
    ST_SCAN   = 10'b00_0100_0000,
    ST_MUL    = 10'b00_1000_0000,
    ST_ADD    = 10'b01_0000_0000,
    ST_DONE   = 10'b10_0000_0000
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign in_i.ready = (state_q == ST_IDLE);
  assign accept     = in_i.valid && in_i.ready;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_sel = ebi_pkg::RD_SCAN;
    case (state_q)
      ST_IDLE: begin
        cmd_o.tick_cap = accept && (in_i.kind == ebi_pkg::KIND_TICK);
        cmd_o.entry_wr = accept && (in_i.kind == ebi_pkg::KIND_LOAD);
        if (cmd_o.tick_cap) begin
          state_d = ST_LAST;
        end
      end
      ST_LAST: begin
        cmd_o.rd_sel = ebi_pkg::RD_LAST;
        state_d      = ST_SUS;
      end
      ST_SUS: begin
        cmd_o.cap_last = 1'b1;
        cmd_o.rd_sel   = ebi_pkg::RD_SUS;
        state_d        = ST_LEND;
      end
      ST_LEND: begin
        cmd_o.cap_sus = 1'b1;
        cmd_o.rd_sel  = ebi_pkg::RD_LEND;
        state_d       = ST_LSTART;
      end
      ST_LSTART: begin
        cmd_o.cap_lend = 1'b1;
        cmd_o.rd_sel   = ebi_pkg::RD_LSTART;
        state_d        = ST_SCAN0;
      end
      ST_SCAN0: begin
        cmd_o.cap_lstart = 1'b1;
        cmd_o.rd_sel     = ebi_pkg::RD_ZERO;
        cmd_o.scan_clr   = 1'b1;
        state_d          = ST_SCAN;
      end
      ST_SCAN: begin
        // The read of the following entry is issued every cycle; it is
        // simply ignored once the scan stops.
        if (st_i.scan_ge) begin
          if (st_i.scan_eq) begin
            cmd_o.lvl_exact = 1'b1;
            state_d         = ST_DONE;
          end else if (st_i.idx_zero) begin
            cmd_o.lvl_end = 1'b1;
            state_d       = ST_DONE;
          end else begin
            cmd_o.cap_seg = 1'b1;
            state_d       = ST_MUL;
          end
        end else begin
          cmd_o.cap_prev = 1'b1;
          if (st_i.scan_end) begin
            cmd_o.lvl_end = 1'b1;
            state_d       = ST_DONE;
          end else begin
            cmd_o.scan_inc = 1'b1;
          end
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.lvl_interp = 1'b1;
        state_d          = ST_DONE;
      end
      ST_DONE: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `EBI_ASSERT(a_tick_starts_walk, clk_i, rst_ni, (accept && in_i.kind == ebi_pkg::KIND_TICK) |=> (state_q == ST_LAST), "tick accept did not start the table walk")
  `EBI_ASSERT(a_mul_then_add, clk_i, rst_ni, (state_q == ST_MUL) |=> (state_q == ST_ADD), "product not followed by the level add")
  `EBI_ASSERT_NEVER(a_no_overwrite, clk_i, rst_ni, cmd_o.out_load && !st_i.out_free, "result loaded over an untaken word")

endmodule

@@ design/ebi_dp.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Envelope datapath
// Configuration, breakpoint table, scan registers, multiplier, output word.
// ----------------------------------------------------------------------------
module ebi_dp #(
  parameter int MAX_POINTS = ebi_pkg::MAX_POINTS_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [ebi_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [ebi_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  ebi_in_if.sink                           in_i,
  ebi_out_if.source                        out_o,
  input  ebi_pkg::cmd_t                    cmd_i,
  output ebi_pkg::status_t                 st_o
);

  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);

  // Configuration registers.
  logic [ebi_pkg::COUNT_W-1:0] count_q;
  logic [ebi_pkg::PTR_W-1:0]   sus_q, lstart_q, lend_q;

  // Tick working registers.
  logic [ebi_pkg::POS_W-1:0]   pos_q, lstart_pos_q, prev_pos_q, delta_q;
  logic [ebi_pkg::VAL_W-1:0]   last_val_q, prev_val_q, prod_q, level_q;
  logic [ebi_pkg::SLOPE_W-1:0] slope_q;
  logic                        rel_q, last_hit_q, sus_hit_q, lend_hit_q;
  logic [IDX_W-1:0]            idx_q;

  // Output word.
  logic                        out_valid_q;
  logic [ebi_pkg::VAL_W-1:0]   out_level_q;
  logic [ebi_pkg::POS_W-1:0]   out_next_q;
  logic                        out_off_q;

  logic [CNT_W-1:0]            n_eff;
  logic [IDX_W-1:0]            last_idx, raddr, waddr;
  logic                        sus_ok, lstart_ok, lend_ok, wr_en, note_off;
  logic [ebi_pkg::POS_W-1:0]   next_pos;
  logic [ebi_pkg::POS_W-1:0]   mul_lo;
  ebi_pkg::entry_t             wentry, rentry;

  function automatic logic idx_ok(logic [ebi_pkg::PTR_W-1:0] ix, logic [CNT_W-1:0] n);
    return (ix != ebi_pkg::NONE_INDEX) && (32'(ix) < 32'(n));
  endfunction

  always_comb begin
    if (count_q == '0) begin
      n_eff = CNT_W'(1);
    end else if (32'(count_q) > MAX_POINTS) begin
      n_eff = CNT_W'(MAX_POINTS);
    end else begin
      n_eff = CNT_W'(count_q);
    end
  end

  assign last_idx  = IDX_W'(n_eff - CNT_W'(1));
  assign sus_ok    = idx_ok(sus_q, n_eff);
  assign lstart_ok = idx_ok(lstart_q, n_eff);
  assign lend_ok   = idx_ok(lend_q, n_eff);

  always_comb begin
    case (cmd_i.rd_sel)
      ebi_pkg::RD_LAST:   raddr = last_idx;
      ebi_pkg::RD_SUS:    raddr = IDX_W'(sus_q);
      ebi_pkg::RD_LEND:   raddr = IDX_W'(lend_q);
      ebi_pkg::RD_LSTART: raddr = IDX_W'(lstart_q);
      ebi_pkg::RD_ZERO:   raddr = '0;
      ebi_pkg::RD_SCAN:   raddr = idx_q + IDX_W'(1);
      default:            raddr = '0;
    endcase
  end

  // Loads beyond the table depth are dropped.
  assign waddr  = IDX_W'(in_i.entry_index);
  assign wr_en  = cmd_i.entry_wr && (32'(in_i.entry_index) < MAX_POINTS);
  assign wentry = '{position: in_i.entry_position,
                    slope:    in_i.entry_slope,
                    value:    in_i.entry_value};

  ebi_ram #(
    .WIDTH (ebi_pkg::ENTRY_W),
    .DEPTH (MAX_POINTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (waddr),
    .wdata_i (wentry),
    .raddr_i (raddr),
    .rdata_o (rentry)
  );

  assign st_o.scan_ge  = rentry.position >= pos_q;
  assign st_o.scan_eq  = rentry.position == pos_q;
  assign st_o.scan_end = (CNT_W'(idx_q) + CNT_W'(1)) == n_eff;
  assign st_o.idx_zero = (idx_q == '0);
  assign st_o.out_free = !out_valid_q || out_o.ready;

  // Only bits 15:8 of the slope-distance product survive the shift and the
  // 8-bit wrap, and the low 16 bits of a product are the same whether the
  // operands are read as signed or unsigned.
  assign mul_lo = 16'(slope_q * delta_q);

  always_comb begin
    next_pos = pos_q + ebi_pkg::POS_W'(1);
    if (sus_hit_q || last_hit_q) begin
      next_pos = pos_q;
    end
    if (lend_hit_q) begin
      next_pos = lstart_pos_q;
    end
  end

  assign note_off = last_hit_q && (last_val_q == '0) &&
                    !(lend_ok && (32'(lend_q) >= 32'(last_idx)));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= ebi_pkg::COUNT_RESET;
      sus_q       <= ebi_pkg::NONE_INDEX;
      lstart_q    <= ebi_pkg::NONE_INDEX;
      lend_q      <= ebi_pkg::NONE_INDEX;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (ebi_pkg::cfg_reg_e'(cfg_idx_i))
          ebi_pkg::CFG_POINT_COUNT: count_q  <= cfg_data_i[ebi_pkg::COUNT_W-1:0];
          ebi_pkg::CFG_SUSTAIN:     sus_q    <= cfg_data_i;
          ebi_pkg::CFG_LOOP_START:  lstart_q <= cfg_data_i;
          ebi_pkg::CFG_LOOP_END:    lend_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.tick_cap) begin
      pos_q <= in_i.position;
      rel_q <= in_i.released;
    end
    if (cmd_i.cap_last) begin
      last_val_q <= rentry.value;
      last_hit_q <= pos_q >= rentry.position;
    end
    if (cmd_i.cap_sus) begin
      sus_hit_q <= !rel_q && sus_ok && (rentry.position == pos_q);
    end
    if (cmd_i.cap_lend) begin
      lend_hit_q <= !rel_q && lend_ok && lstart_ok && (rentry.position == pos_q);
    end
    if (cmd_i.cap_lstart) begin
      lstart_pos_q <= rentry.position;
    end
    if (cmd_i.scan_clr) begin
      idx_q <= '0;
    end else if (cmd_i.scan_inc) begin
      idx_q <= idx_q + IDX_W'(1);
    end
    if (cmd_i.cap_prev) begin
      prev_pos_q <= rentry.position;
      prev_val_q <= rentry.value;
    end
    if (cmd_i.cap_seg) begin
      slope_q <= rentry.slope;
      delta_q <= pos_q - prev_pos_q;
    end
    if (cmd_i.mul) begin
      prod_q <= mul_lo[15:8];
    end
    if (cmd_i.lvl_exact) begin
      level_q <= rentry.value;
    end else if (cmd_i.lvl_end) begin
      level_q <= last_val_q;
    end else if (cmd_i.lvl_interp) begin
      level_q <= prod_q + prev_val_q;
    end
    if (cmd_i.out_load) begin
      out_level_q <= level_q;
      out_next_q  <= next_pos;
      out_off_q   <= note_off;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.level         = out_level_q;
  assign out_o.next_position = out_next_q;
  assign out_o.note_off_arm  = out_off_q;

endmodule

@@ design/envelope_breakpoint_interpolator_top.sv @@
`timescale 1ns / 1ps
// Sequence: an accepted tick word steps through the reads of the last, sustain, loop end
// and loop start entries, then a scan of k entries (1 to the entry count) through the
// single table read port, a multiply and an add when the level is interpolated, and a
// wait for a free output register; no word is taken until it is back at rest.
// Reset is asynchronous and active low: it clears the sequencer, the output valid and
// the configuration (one entry, no sustain, no loop); the table contents stay undefined.
// ----------------------------------------------------------------------------
// Envelope breakpoint interpolator
// Piecewise-linear envelope generator over a small breakpoint table.
// ----------------------------------------------------------------------------
module envelope_breakpoint_interpolator_top #(
  parameter int MAX_POINTS = ebi_pkg::MAX_POINTS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [ebi_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [ebi_pkg::CFG_DATA_W-1:0] cfg_data_i,
  ebi_in_if.sink                         in_i,
  ebi_out_if.source                      out_o
);

  // The sequencer walks each tick through a fixed order of table reads: the
  // last entry in use, the sustain entry, the loop end and the loop start.
  // Those reads settle the next position and the note-off flag. It then scans
  // the table from entry zero until it finds the first breakpoint at or past
  // the position. An exact match returns that entry's value; running off
  // either end of the table returns the last entry's value; otherwise the
  // segment is interpolated from the entry below with the slope of the entry
  // above, through one multiply and one add.
  //
  // The result sits in an output register, so a new word can be accepted as
  // soon as the sequencer is back at rest, even while the previous result
  // still waits to be taken. Configuration must be written only when the block is
  // quiet; the block itself does not enforce this.

  ebi_pkg::cmd_t    cmd;
  ebi_pkg::status_t st;

  ebi_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .st_i   (st),
    .cmd_o  (cmd)
  );

  ebi_dp #(
    .MAX_POINTS (MAX_POINTS)
  ) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_i),
    .out_o      (out_o),
    .cmd_i      (cmd),
    .st_o       (st)
  );

endmodule
